>>> rtl/assert_macros.svh
// Assertion macros shared by the FFT modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RFFT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define RFFT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rfft_pkg.sv
package rfft_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int OUT_BITS     = 28;
    localparam int INDEX_BITS   = 10;
    localparam int CFG_BITS     = 4;
    localparam int MAX_POINTS   = 1024;
    localparam int TWIDDLE_BITS = 16;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    typedef enum logic {
        OP_LOAD,
        OP_FETCH
    } op_t;

    typedef struct packed {
        logic                          cmd;
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0]   bin_re;
        logic signed [OUT_BITS-1:0]   bin_im;
        logic        [INDEX_BITS-1:0] bin_index;
        logic                         last_bin;
        logic                         ready_res;
    } out_item_t;

    typedef struct packed {
        op_t                        op;
        logic signed [OUT_BITS-1:0] re;
        logic signed [OUT_BITS-1:0] im;
    } cmd_t;

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] udiv64(logic [63:0] x, logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], x[i]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic signed [63:0] taylor_cos(logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               done;
        term = ONE_Q62;
        sum  = signed'(ONE_Q62);
        done = 1'b0;
        for (int n = 1; n <= 40; n++) begin
            if (!done) begin
                term = udiv64(mul_q62(term, x), 64'(2 * n - 1));
                term = udiv64(mul_q62(term, x), 64'(2 * n));
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
        end
        return sum;
    endfunction

    function automatic int round_tw(logic signed [63:0] v, int twbits);
        int          s;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] lim;
        s   = 63 - twbits;
        m   = (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
        r   = (m + (64'd1 << (s - 1))) >> s;
        lim = (64'd1 << (twbits - 1)) - 64'd1;
        if (r > lim) begin
            r = lim;
        end
        return (v < 0) ? -int'(r) : int'(r);
    endfunction

    // Rounded cosine of the angle 2*pi*m/2^tab_log, for m up to a quarter turn.
    function automatic int tw_quarter(int m, int tab_log, int twbits);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] th;
        q  = PI_Q62 >> (tab_log - 1);
        r  = PI_Q62 & ((64'd1 << (tab_log - 1)) - 64'd1);
        th = q * 64'(m) + ((r * 64'(m)) >> (tab_log - 1));
        return round_tw(taylor_cos(th), twbits);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat_out(logic signed [OUT_BITS+2:0] v);
        logic signed [OUT_BITS+2:0] hi;
        logic signed [OUT_BITS+2:0] lo;
        hi = (OUT_BITS + 3)'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
        lo = (OUT_BITS + 3)'(-(64'sd1 <<< (OUT_BITS - 1)));
        if (v > hi) begin
            return OUT_BITS'(hi);
        end else if (v < lo) begin
            return OUT_BITS'(lo);
        end
        return OUT_BITS'(v);
    endfunction

endpackage

>>> rtl/rfft_front.sv
`include "assert_macros.svh"

module rfft_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rfft_pkg::in_item_t item,
    output logic              q_valid,
    input  logic              q_pop,
    output rfft_pkg::cmd_t    q_item
);

    localparam int FDEPTH = 4;
    localparam int PW     = $clog2(FDEPTH);

    rfft_pkg::cmd_t   slot_reg [FDEPTH];
    rfft_pkg::cmd_t   cls;
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      cnt_reg;
    logic [PW:0]      cnt_next;
    logic             push_acc;
    logic             pop_acc;

    always_comb
    begin
        cls.op = item.cmd ? rfft_pkg::OP_FETCH : rfft_pkg::OP_LOAD;
        cls.re = rfft_pkg::OUT_BITS'(item.sample_re);
        cls.im = rfft_pkg::OUT_BITS'(item.sample_im);
    end

    assign full     = (cnt_reg == (PW + 1)'(FDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push_acc = push && !full;
    assign pop_acc  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push_acc ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_acc ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW + 1)'(push_acc) - (PW + 1)'(pop_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    `RFFT_ASSERT(a_front_cnt_bound, cnt_reg <= (PW + 1)'(FDEPTH), "command queue overflow")
    `RFFT_ASSERT_NEXT(a_front_fill, push_acc && !pop_acc, cnt_reg == $past(cnt_reg) + 1'b1, "command queue lost a transaction")

endmodule

>>> rtl/rfft_twrom.sv
module rfft_twrom #(
    parameter int TAB_LOG      = 10,
    parameter int TWIDDLE_BITS = rfft_pkg::TWIDDLE_BITS
) (
    input  logic                           clk,
    input  logic [TAB_LOG-2:0]             k,
    output logic signed [TWIDDLE_BITS-1:0] wr,
    output logic signed [TWIDDLE_BITS-1:0] wi
);

    localparam int KW = TAB_LOG - 1;
    localparam int Q4 = 1 << (TAB_LOG - 2);
    localparam logic [KW:0] HALF = (KW + 1)'(1) << KW;
    localparam logic [KW:0] QTR  = (KW + 1)'(Q4);

    logic signed [TWIDDLE_BITS-1:0] quarter [Q4 + 1];
    logic signed [TWIDDLE_BITS-1:0] c;
    logic signed [TWIDDLE_BITS-1:0] s;
    logic [KW-1:0]                  ci;
    logic [KW-1:0]                  si;
    logic                           first;

    for (genvar m = 0; m <= Q4; m++)
    begin : g_tab
        localparam logic signed [TWIDDLE_BITS-1:0] VAL =
            TWIDDLE_BITS'(rfft_pkg::tw_quarter(m, TAB_LOG, TWIDDLE_BITS));
        assign quarter[m] = VAL;
    end

    always_comb
    begin
        first = ({1'b0, k} <= QTR);
        if (first)
        begin
            ci = k;
            si = KW'(QTR - {1'b0, k});
        end
        else
        begin
            ci = KW'(HALF - {1'b0, k});
            si = KW'({1'b0, k} - QTR);
        end
        c = first ? quarter[ci] : -quarter[ci];
        s = quarter[si];
    end

    always_ff @(posedge clk)
    begin
        wr <= c;
        wi <= -s;
    end

endmodule

>>> rtl/rfft_resq.sv
module rfft_resq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_push,
    input  rfft_pkg::out_item_t in_item,
    output logic                in_full,
    output logic                out_empty,
    input  logic                out_pop,
    output rfft_pkg::out_item_t out_item
);

    rfft_pkg::out_item_t slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic                push_acc;
    logic                pop_acc;

    assign in_full   = (cnt_reg == 2'd2);
    assign out_empty = (cnt_reg == 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push_acc  = in_push && !in_full;
    assign pop_acc   = out_pop && !out_empty;
    assign cnt_next  = cnt_reg + 2'(push_acc) - 2'(pop_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push_acc;
            rd_ptr_reg <= rd_ptr_reg ^ pop_acc;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/rfft_core.sv
`include "assert_macros.svh"

module rfft_core #(
    parameter int MAX_POINTS   = rfft_pkg::MAX_POINTS,
    parameter int TWIDDLE_BITS = rfft_pkg::TWIDDLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rfft_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  rfft_pkg::cmd_t                     q_item,
    input  logic                               res_full,
    output logic                               res_push,
    output rfft_pkg::out_item_t                res_item
);

    localparam int TAB_LOG   = $clog2(MAX_POINTS + 1) - 1;
    localparam int AW        = TAB_LOG;
    localparam int DEPTH     = 1 << AW;
    localparam int LW        = $clog2(TAB_LOG + 1);
    localparam int KW        = TAB_LOG - 1;
    localparam int OB        = rfft_pkg::OUT_BITS;
    localparam int DW        = 2 * OB;
    localparam int PW        = OB + TWIDDLE_BITS;
    localparam int SW        = PW + 1;
    localparam int VW        = OB + 2;
    localparam int AWW       = OB + 3;
    localparam int LOG_RESET = (TAB_LOG < 10) ? TAB_LOG : 10;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (TWIDDLE_BITS - 2);

    typedef enum logic [3:0] {
        IDLE,
        FETCH,
        BR_RD,
        BR_W1,
        BR_W2,
        BF_RD,
        BF_MUL,
        BF_ADD,
        BF_WRA,
        BF_WRB
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [LW-1:0]  log_reg;
    logic [LW-1:0]  log_next;
    logic [AW:0]    load_cnt_reg;
    logic [AW:0]    load_cnt_next;
    logic [AW-1:0]  rd_idx_reg;
    logic [AW-1:0]  rd_idx_next;
    logic           valid_reg;
    logic           valid_next;
    logic [AW-1:0]  i_reg;
    logic [AW-1:0]  i_next;
    logic [LW-1:0]  stage_reg;
    logic [LW-1:0]  stage_next;

    logic [DW-1:0]  mem [DEPTH];
    logic [DW-1:0]  qa_reg;
    logic [DW-1:0]  qb_reg;
    logic           mem_re;
    logic           mem_we;
    logic [AW-1:0]  ra;
    logic [AW-1:0]  rb;
    logic [AW-1:0]  waddr;
    logic [DW-1:0]  wdata;

    logic [AW:0]    n;
    logic [AW:0]    cnt_eff;
    logic [AW:0]    cnt_inc;
    logic [AW-1:0]  rev_full;
    logic [AW-1:0]  rev;
    logic [AW-1:0]  hm;
    logic [AW-1:0]  a_addr;
    logic [AW-1:0]  b_addr;
    logic [AW-1:0]  jk;
    logic [KW-1:0]  k;
    logic           last_bin;

    logic signed [TWIDDLE_BITS-1:0] wr;
    logic signed [TWIDDLE_BITS-1:0] wi;
    logic signed [OB-1:0]           br;
    logic signed [OB-1:0]           bi;
    logic signed [OB-1:0]           ur;
    logic signed [OB-1:0]           ui;
    logic signed [PW-1:0]           p_rr_reg;
    logic signed [PW-1:0]           p_ii_reg;
    logic signed [PW-1:0]           p_ri_reg;
    logic signed [PW-1:0]           p_ir_reg;
    logic signed [SW-1:0]           sum_r;
    logic signed [SW-1:0]           sum_i;
    logic signed [VW-1:0]           vr_reg;
    logic signed [VW-1:0]           vi_reg;
    logic [DW-1:0]                  resb_reg;
    logic [DW-1:0]                  a_out;
    logic [DW-1:0]                  b_out;

    rfft_twrom #(
        .TAB_LOG      (TAB_LOG),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_twrom (
        .clk (clk),
        .k   (k),
        .wr  (wr),
        .wi  (wi)
    );

    always_comb
    begin
        n = (AW + 1)'(1) << log_reg;
        for (int bx = 0; bx < AW; bx++)
        begin
            rev_full[bx] = i_reg[AW - 1 - bx];
        end
        rev    = rev_full >> (LW'(AW) - log_reg);
        hm     = (AW'(1) << (stage_reg - 1'b1)) - AW'(1);
        a_addr = ((i_reg & ~hm) << 1) | (i_reg & hm);
        b_addr = a_addr | (hm + AW'(1));
        jk     = (i_reg & hm) << (LW'(TAB_LOG) - stage_reg);
        k      = KW'(jk);
        last_bin = ({1'b0, rd_idx_reg} == n - 1'b1);
        cnt_eff  = (valid_reg || load_cnt_reg >= n) ? '0 : load_cnt_reg;
        cnt_inc  = cnt_eff + 1'b1;
    end

    always_comb
    begin
        br    = qb_reg[DW-1:OB];
        bi    = qb_reg[OB-1:0];
        ur    = qa_reg[DW-1:OB];
        ui    = qa_reg[OB-1:0];
        sum_r = SW'(p_rr_reg) - SW'(p_ii_reg);
        sum_i = SW'(p_ri_reg) + SW'(p_ir_reg);
        a_out = {rfft_pkg::sat_out(AWW'(ur) + AWW'(vr_reg)),
                 rfft_pkg::sat_out(AWW'(ui) + AWW'(vi_reg))};
        b_out = {rfft_pkg::sat_out(AWW'(ur) - AWW'(vr_reg)),
                 rfft_pkg::sat_out(AWW'(ui) - AWW'(vi_reg))};
    end

    always_comb
    begin
        state_next    = state_reg;
        log_next      = log_reg;
        load_cnt_next = load_cnt_reg;
        rd_idx_next   = rd_idx_reg;
        valid_next    = valid_reg;
        i_next        = i_reg;
        stage_next    = stage_reg;
        q_pop         = 1'b0;
        res_push      = 1'b0;
        res_item      = '0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        ra            = a_addr;
        rb            = b_addr;
        waddr         = a_addr;
        wdata         = a_out;

        unique case (state_reg)
            IDLE:
            begin
                if (q_valid && !res_full)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == rfft_pkg::OP_LOAD)
                    begin
                        if (valid_reg)
                        begin
                            valid_next  = 1'b0;
                            rd_idx_next = '0;
                        end
                        mem_we = 1'b1;
                        waddr  = cnt_eff[AW-1:0];
                        wdata  = {q_item.re, q_item.im};
                        if (cnt_inc == n)
                        begin
                            load_cnt_next = '0;
                            rd_idx_next   = '0;
                            i_next        = '0;
                            state_next    = BR_RD;
                        end
                        else
                        begin
                            load_cnt_next = cnt_inc;
                        end
                    end
                    else if (valid_reg)
                    begin
                        mem_re     = 1'b1;
                        ra         = rd_idx_reg;
                        state_next = FETCH;
                    end
                    else
                    begin
                        res_push = 1'b1;
                    end
                end
            end
            FETCH:
            begin
                res_push           = 1'b1;
                res_item.bin_re    = qa_reg[DW-1:OB];
                res_item.bin_im    = qa_reg[OB-1:0];
                res_item.bin_index = rfft_pkg::INDEX_BITS'(rd_idx_reg);
                res_item.last_bin  = last_bin;
                res_item.ready_res = 1'b1;
                if (last_bin)
                begin
                    rd_idx_next = '0;
                    valid_next  = 1'b0;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                state_next = IDLE;
            end
            BR_RD:
            begin
                if (i_reg < rev)
                begin
                    mem_re     = 1'b1;
                    ra         = i_reg;
                    rb         = rev;
                    state_next = BR_W1;
                end
                else if ({1'b0, i_reg} == n - 1'b1)
                begin
                    i_next     = '0;
                    stage_next = LW'(1);
                    state_next = BF_RD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            BR_W1:
            begin
                mem_we     = 1'b1;
                waddr      = i_reg;
                wdata      = qb_reg;
                state_next = BR_W2;
            end
            BR_W2:
            begin
                mem_we     = 1'b1;
                waddr      = rev;
                wdata      = qa_reg;
                i_next     = i_reg + 1'b1;
                state_next = BR_RD;
            end
            BF_RD:
            begin
                mem_re     = 1'b1;
                state_next = BF_MUL;
            end
            BF_MUL:
            begin
                state_next = BF_ADD;
            end
            BF_ADD:
            begin
                state_next = BF_WRA;
            end
            BF_WRA:
            begin
                mem_we     = 1'b1;
                state_next = BF_WRB;
            end
            BF_WRB:
            begin
                mem_we = 1'b1;
                waddr  = b_addr;
                wdata  = resb_reg;
                if ({1'b0, i_reg} == (n >> 1) - 1'b1)
                begin
                    i_next = '0;
                    if (stage_reg == log_reg)
                    begin
                        valid_next  = 1'b1;
                        rd_idx_next = '0;
                        state_next  = IDLE;
                    end
                    else
                    begin
                        stage_next = stage_reg + 1'b1;
                        state_next = BF_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = BF_RD;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                log_next = LW'(1);
            end
            else if (cfg_data > rfft_pkg::CFG_BITS'(TAB_LOG))
            begin
                log_next = LW'(TAB_LOG);
            end
            else
            begin
                log_next = LW'(cfg_data);
            end
            load_cnt_next = '0;
            rd_idx_next   = '0;
            valid_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            log_reg      <= LW'(LOG_RESET);
            load_cnt_reg <= '0;
            rd_idx_reg   <= '0;
            valid_reg    <= 1'b0;
            i_reg        <= '0;
            stage_reg    <= LW'(1);
        end
        else
        begin
            state_reg    <= state_next;
            log_reg      <= log_next;
            load_cnt_reg <= load_cnt_next;
            rd_idx_reg   <= rd_idx_next;
            valid_reg    <= valid_next;
            i_reg        <= i_next;
            stage_reg    <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            qa_reg <= mem[ra];
            qb_reg <= mem[rb];
        end
        if (state_reg == BF_MUL)
        begin
            p_rr_reg <= br * wr;
            p_ii_reg <= bi * wi;
            p_ri_reg <= br * wi;
            p_ir_reg <= bi * wr;
        end
        if (state_reg == BF_ADD)
        begin
            vr_reg <= VW'((sum_r + RND) >>> (TWIDDLE_BITS - 1));
            vi_reg <= VW'((sum_i + RND) >>> (TWIDDLE_BITS - 1));
        end
        if (state_reg == BF_WRA)
        begin
            resb_reg <= b_out;
        end
    end

    `RFFT_ASSERT(a_core_res_room, !res_push || !res_full, "result pushed into a full queue")
    `RFFT_ASSERT(a_core_busy_no_pop, state_reg == IDLE || !q_pop, "command taken while busy")

endmodule

>>> rtl/radix2_fft.sv
// A load is written into the store as it is taken; a fetch reads the store
// and its result is registered in the result queue before it reaches the
// result ports. The last load of an N-point frame starts the transform,
// which holds the command queue through bit reversal, then one butterfly at
// a time (read, multiply, add, write back) in the single 2R/1W store.
// Reset (rst_n, asynchronous, active low) empties both queues and the frame.
module radix2_fft #(
    parameter int MAX_POINTS   = rfft_pkg::MAX_POINTS,
    parameter int TWIDDLE_BITS = rfft_pkg::TWIDDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  rfft_pkg::in_item_t            item,
    output logic                          empty,
    input  logic                          pop,
    output rfft_pkg::out_item_t           result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfft_pkg::CFG_BITS-1:0] cfg_data
);

    logic                q_valid;
    logic                q_pop;
    rfft_pkg::cmd_t      q_item;
    logic                res_full;
    logic                res_push;
    rfft_pkg::out_item_t res_item;

    assign cfg_ready = 1'b1;

    rfft_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    rfft_core #(
        .MAX_POINTS   (MAX_POINTS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .res_full (res_full),
        .res_push (res_push),
        .res_item (res_item)
    );

    rfft_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (res_push),
        .in_item   (res_item),
        .in_full   (res_full),
        .out_empty (empty),
        .out_pop   (pop),
        .out_item  (result)
    );

endmodule

>>> test/tb_radix2_fft.sv
module tb_radix2_fft;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAB_LOG        = 10;

    class fft_scoreboard;
        rfft_pkg::out_item_t expected_bins[$];
        int          errors;
        int          lg;
        int          loaded;
        int          next_bin;
        bit          frame_done;
        longint      bin_re[rfft_pkg::MAX_POINTS];
        longint      bin_im[rfft_pkg::MAX_POINTS];
        longint      tw_re[rfft_pkg::MAX_POINTS / 2];
        longint      tw_im[rfft_pkg::MAX_POINTS / 2];

        function new();
            build_twiddles();
            lg = TAB_LOG;
        endfunction

        function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        function longint series_cos(logic [63:0] x);
            logic [63:0] term;
            longint      sum;
            term = 64'h4000000000000000;
            sum  = longint'(term);
            for (int n = 1; n <= 40; n++)
            begin
                term = q62_mul(term, x) / 64'(2 * n - 1);
                term = q62_mul(term, x) / 64'(2 * n);
                if (term == 0)
                begin
                    break;
                end
                if (n % 2 == 1)
                begin
                    sum -= longint'(term);
                end
                else
                begin
                    sum += longint'(term);
                end
            end
            return sum;
        endfunction

        function longint to_q15(longint v);
            logic [63:0] m;
            logic [63:0] r;
            m = (v < 0) ? -v : v;
            r = (m + (64'd1 << 46)) >> 47;
            if (r > 32767)
            begin
                r = 32767;
            end
            return (v < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void build_twiddles();
            longint      quarter[rfft_pkg::MAX_POINTS / 4 + 1];
            logic [63:0] q;
            logic [63:0] r;
            logic [63:0] th;
            longint      c;
            longint      s;
            q = 64'hC90FDAA22168C234 >> (TAB_LOG - 1);
            r = 64'hC90FDAA22168C234 & ((64'd1 << (TAB_LOG - 1)) - 1);
            for (int k = 0; k <= rfft_pkg::MAX_POINTS / 4; k++)
            begin
                th = q * 64'(k) + ((r * 64'(k)) >> (TAB_LOG - 1));
                quarter[k] = series_cos(th);
            end
            for (int k = 0; k < rfft_pkg::MAX_POINTS / 2; k++)
            begin
                if (k <= rfft_pkg::MAX_POINTS / 4)
                begin
                    c = quarter[k];
                    s = quarter[rfft_pkg::MAX_POINTS / 4 - k];
                end
                else
                begin
                    c = -quarter[rfft_pkg::MAX_POINTS / 2 - k];
                    s = quarter[k - rfft_pkg::MAX_POINTS / 4];
                end
                tw_re[k] = to_q15(c);
                tw_im[k] = -to_q15(s);
            end
        endfunction

        function longint clip28(longint v);
            if (v > 134217727)
            begin
                return 134217727;
            end
            if (v < -134217728)
            begin
                return -134217728;
            end
            return v;
        endfunction

        function void run_fft();
            int     n;
            int     rev;
            int     half;
            int     stride;
            int     a;
            int     b;
            longint t;
            longint vr;
            longint vi;
            longint ur;
            longint ui;
            n = 1 << lg;
            for (int i = 0; i < n; i++)
            begin
                rev = 0;
                for (int k = 0; k < lg; k++)
                begin
                    rev = (rev << 1) | ((i >> k) & 1);
                end
                if (i < rev)
                begin
                    t = bin_re[i]; bin_re[i] = bin_re[rev]; bin_re[rev] = t;
                    t = bin_im[i]; bin_im[i] = bin_im[rev]; bin_im[rev] = t;
                end
            end
            for (int len = 2; len <= n; len *= 2)
            begin
                half   = len / 2;
                stride = rfft_pkg::MAX_POINTS / len;
                for (int i = 0; i < n; i += len)
                begin
                    for (int j = 0; j < half; j++)
                    begin
                        a  = i + j;
                        b  = a + half;
                        vr = (bin_re[b] * tw_re[j * stride] - bin_im[b] * tw_im[j * stride]
                              + 16384) >>> 15;
                        vi = (bin_re[b] * tw_im[j * stride] + bin_im[b] * tw_re[j * stride]
                              + 16384) >>> 15;
                        ur = bin_re[a];
                        ui = bin_im[a];
                        bin_re[a] = clip28(ur + vr);
                        bin_im[a] = clip28(ui + vi);
                        bin_re[b] = clip28(ur - vr);
                        bin_im[b] = clip28(ui - vi);
                    end
                end
            end
        endfunction

        function void set_size(logic [rfft_pkg::CFG_BITS-1:0] v);
            lg         = (v < 1) ? 1 : ((v > TAB_LOG) ? TAB_LOG : int'(v));
            loaded     = 0;
            next_bin   = 0;
            frame_done = 0;
        endfunction

        function void note_input(rfft_pkg::in_item_t it);
            rfft_pkg::out_item_t e;
            int                  n;
            n = 1 << lg;
            if (it.cmd == rfft_pkg::OP_LOAD)
            begin
                if (frame_done)
                begin
                    frame_done = 0;
                    next_bin   = 0;
                    loaded     = 0;
                end
                bin_re[loaded] = it.sample_re;
                bin_im[loaded] = it.sample_im;
                loaded++;
                if (loaded == n)
                begin
                    run_fft();
                    loaded     = 0;
                    next_bin   = 0;
                    frame_done = 1;
                end
                return;
            end
            e = '0;
            if (frame_done)
            begin
                e.bin_re    = rfft_pkg::OUT_BITS'(bin_re[next_bin]);
                e.bin_im    = rfft_pkg::OUT_BITS'(bin_im[next_bin]);
                e.bin_index = rfft_pkg::INDEX_BITS'(next_bin);
                e.last_bin  = (next_bin == n - 1);
                e.ready_res = 1'b1;
                next_bin++;
                if (next_bin == n)
                begin
                    next_bin   = 0;
                    frame_done = 0;
                end
            end
            expected_bins.push_back(e);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("%0t: %s is %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(rfft_pkg::out_item_t got);
            rfft_pkg::out_item_t e;
            if (expected_bins.size() == 0)
            begin
                report_mismatch("unexpected result transaction, bin_index", got.bin_index, -1);
                return;
            end
            e = expected_bins.pop_front();
            if (got.bin_re !== e.bin_re)
                report_mismatch("bin_re", got.bin_re, e.bin_re);
            if (got.bin_im !== e.bin_im)
                report_mismatch("bin_im", got.bin_im, e.bin_im);
            if (got.bin_index !== e.bin_index)
                report_mismatch("bin_index", got.bin_index, e.bin_index);
            if (got.last_bin !== e.last_bin)
                report_mismatch("last_bin", got.last_bin, e.last_bin);
            if (got.ready_res !== e.ready_res)
                report_mismatch("ready_res", got.ready_res, e.ready_res);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    rfft_pkg::in_item_t            item;
    logic                          empty;
    logic                          pop;
    rfft_pkg::out_item_t           result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rfft_pkg::CFG_BITS-1:0] cfg_data;

    fft_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            quiet_cycles;

    radix2_fft uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_result(result);
        end
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task push_item(logic cmd, logic [15:0] re, logic [15:0] im);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        push           = 1'b1;
        item.cmd       = cmd;
        item.sample_re = re;
        item.sample_im = im;
        do
            @(posedge clk);
        while (full);
        sb.note_input(item);
    endtask

    function logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task settle_and_configure(logic [rfft_pkg::CFG_BITS-1:0] v);
        int n;
        @(negedge clk);
        push = 1'b0;
        while (sb.expected_bins.size() != 0)
        begin
            @(posedge clk);
        end
        n = 1 << sb.lg;
        repeat (3 * n + 3 * n * sb.lg + 50) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_size(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task run_frame(int extra_fetch);
        int n;
        n = 1 << sb.lg;
        for (int i = 0; i < n; i++)
        begin
            push_item(rfft_pkg::OP_LOAD, rand_sample(), rand_sample());
        end
        for (int i = 0; i < n + extra_fetch; i++)
        begin
            push_item(rfft_pkg::OP_FETCH, 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        sb             = new();
        push           = 1'b0;
        item           = '0;
        pop            = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_item(rfft_pkg::OP_FETCH, 16'hFFFF, 16'hFFFF);
        settle_and_configure(4'd0);
        push_item(rfft_pkg::OP_LOAD, 16'h7FFF, 16'h8000);
        push_item(rfft_pkg::OP_LOAD, 16'h8000, 16'h7FFF);
        push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);
        push_item(rfft_pkg::OP_LOAD, 16'h7FFF, 16'h7FFF);
        push_item(rfft_pkg::OP_LOAD, 16'h7FFF, 16'h7FFF);
        push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);
        push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);
        push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);
        settle_and_configure(4'd3);
        push_item(rfft_pkg::OP_LOAD, 16'h8000, 16'h8000);
        push_item(rfft_pkg::OP_LOAD, 16'h0001, 16'hFFFF);
        settle_and_configure(4'd2);
        push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);
        run_frame(1);

        // Largest frame once, with the receiver stalling often.
        recv_stall_pct = 72;
        send_idle_pct  = 6;
        settle_and_configure(4'd15);
        for (int i = 0; i < (1 << TAB_LOG); i++)
        begin
            push_item(rfft_pkg::OP_LOAD, rand_sample(), rand_sample());
        end
        repeat (8)
        begin
            push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);
        end
        settle_and_configure(4'd10);
        push_item(rfft_pkg::OP_FETCH, 16'h0, 16'h0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 6 : ((phase == 1) ? 72 : 0);
            recv_stall_pct = (phase == 0) ? 72 : ((phase == 1) ? 6 : 0);
            for (int blk = 0; blk < 2; blk++)
            begin
                settle_and_configure(rfft_pkg::CFG_BITS'($urandom_range(5, 1)));
                repeat (2)
                begin
                    if ($urandom_range(9) < 7)
                    begin
                        run_frame(int'($urandom_range(1)));
                    end
                    else
                    begin
                        repeat ($urandom_range(6, 1))
                        begin
                            push_item(1'($urandom_range(1)), rand_sample(), rand_sample());
                        end
                    end
                end
                if (phase == 1 && blk == 1)
                begin
                    @(negedge clk);
                    push = 1'b0;
                    while (sb.expected_bins.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
        end

        @(negedge clk);
        push = 1'b0;
        while (sb.expected_bins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
